>>> rtl/core/zoh_pkg.sv
// ----------------------------------------------------------------------------
// zoh_pkg
// shared types and constants of the zone occupancy block
// ----------------------------------------------------------------------------
package zoh_pkg;

  // default datapath widths
  localparam int COORD_WIDTH_DEF = 32;
  localparam int TIMER_WIDTH_DEF = 32;

  // half-width offset registers have a fixed width
  localparam int HALF_WIDTH_BITS = 21;

  // hold-off reset value in ticks
  localparam int HOLDOFF_RESET = 100;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_END_ONE_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_ONE_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_TWO_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_TWO_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH_DX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH_DY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FREE      = 3'd6;

  // action codes on the request port
  localparam int ACTION_W = 2;
  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POINT  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FINISH = 2'd2;

  // classified operation carried from front to back
  typedef enum logic [1:0] {
    OP_TICK,
    OP_POINT,
    OP_FINISH
  } zoh_op_e;

  localparam int OP_W = 2;

  // queue depths (powers of two)
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // one result: occupied and hit_in_set
  typedef struct packed {
    logic occupied;
    logic hit_in_set;
  } zoh_result_t;

endpackage

>>> rtl/core/zoh_fifo.sv
// ----------------------------------------------------------------------------
// zoh_fifo
// small synchronous queue with registered storage and head read-out
// ----------------------------------------------------------------------------
module zoh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o  = (count_q == CNTW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> rtl/core/zoh_front.sv
// ----------------------------------------------------------------------------
// zoh_front
// request intake: classifies the action and stages it for the back end
// ----------------------------------------------------------------------------
module zoh_front #(
  parameter int CW = zoh_pkg::COORD_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [zoh_pkg::ACTION_W-1:0] action_i,
  input  logic [CW-1:0]                point_x_i,
  input  logic [CW-1:0]                point_y_i,
  output logic                         q_wr_o,
  output logic [zoh_pkg::OP_W+2*CW-1:0] q_wdata_o,
  input  logic                         q_full_i
);

  logic            valid_q, valid_d;
  zoh_pkg::zoh_op_e op_q, op_d;
  logic [CW-1:0]   px_q, py_q;
  logic            take, keep, drain;

  // one staging register; it drains into the queue whenever the queue has room
  assign drain = valid_q && !q_full_i;
  assign full  = valid_q && q_full_i;
  assign take  = push && !full;

  always_comb begin
    op_d = op_q;
    keep = 1'b0;
    unique case (action_i)
      zoh_pkg::ACT_TICK: begin
        op_d = zoh_pkg::OP_TICK;
        keep = 1'b1;
      end
      zoh_pkg::ACT_POINT: begin
        op_d = zoh_pkg::OP_POINT;
        keep = 1'b1;
      end
      zoh_pkg::ACT_FINISH: begin
        op_d = zoh_pkg::OP_FINISH;
        keep = 1'b1;
      end
      default: begin
        // unused action: taken and dropped
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = keep;
    end else if (drain) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && keep) begin
      op_q <= op_d;
      px_q <= point_x_i;
      py_q <= point_y_i;
    end
  end

  assign q_wr_o    = drain;
  assign q_wdata_o = {op_q, px_q, py_q};

endmodule

>>> rtl/core/zoh_back.sv
// ----------------------------------------------------------------------------
// zoh_back
// geometry pipeline and occupancy state: runs classified operations in order
// ----------------------------------------------------------------------------
module zoh_back #(
  parameter int CW = zoh_pkg::COORD_WIDTH_DEF,
  parameter int TW = zoh_pkg::TIMER_WIDTH_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // operation queue
  input  logic                                      q_empty_i,
  input  logic [zoh_pkg::OP_W+2*CW-1:0]             q_rdata_i,
  output logic                                      q_rd_o,
  // zone configuration
  input  logic signed [CW-1:0]                      e1x_i,
  input  logic signed [CW-1:0]                      e1y_i,
  input  logic signed [CW-1:0]                      e2x_i,
  input  logic signed [CW-1:0]                      e2y_i,
  input  logic signed [zoh_pkg::HALF_WIDTH_BITS-1:0] dx_i,
  input  logic signed [zoh_pkg::HALF_WIDTH_BITS-1:0] dy_i,
  input  logic [TW-1:0]                             min_free_i,
  // result queue
  output logic                                      res_wr_o,
  output zoh_pkg::zoh_result_t                      res_o,
  input  logic                                      res_full_i
);

  localparam int HW = zoh_pkg::HALF_WIDTH_BITS;
  localparam int BW = (CW > HW) ? CW : HW;
  localparam int RW = BW + 2;                    // point minus corner
  localparam int AW = (CW + 1 > HW) ? CW + 1 : HW; // edge or offset operand
  localparam int LO = RW / 2;
  localparam int HI = RW - LO;
  localparam int PW = AW + RW;                   // full product
  localparam int SW = PW + 1;                    // sum of two products
  localparam int NMUL = 8;

  // ---- static geometry derived from configuration ----
  logic signed [RW-1:0] ax_q, ay_q, cx_q, cy_q;  // corners A and C
  logic signed [AW-1:0] ex_q, ey_q, dxa_q, dya_q;

  always_ff @(posedge clk_i) begin
    ax_q  <= RW'(e1x_i) + RW'(dx_i);
    ay_q  <= RW'(e1y_i) + RW'(dy_i);
    cx_q  <= RW'(e2x_i) - RW'(dx_i);
    cy_q  <= RW'(e2y_i) - RW'(dy_i);
    ex_q  <= AW'(e2x_i) - AW'(e1x_i);
    ey_q  <= AW'(e2y_i) - AW'(e1y_i);
    dxa_q <= AW'(dx_i);
    dya_q <= AW'(dy_i);
  end

  // ---- pipeline control ----
  logic             en;
  logic             v1_q, v2_q, v3_q, v4_q;
  zoh_pkg::zoh_op_e op1_q, op2_q, op3_q, op4_q;
  zoh_pkg::zoh_op_e q_op;
  logic signed [CW-1:0] q_px, q_py;

  assign q_op = zoh_pkg::zoh_op_e'(q_rdata_i[2*CW +: zoh_pkg::OP_W]);
  assign q_px = q_rdata_i[CW +: CW];
  assign q_py = q_rdata_i[0 +: CW];

  // the whole pipe holds only when a finish cannot leave
  assign en   = !(v4_q && (op4_q == zoh_pkg::OP_FINISH) && res_full_i);
  assign q_rd_o = en && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= !q_empty_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q <= q_op;
      op2_q <= op1_q;
      op3_q <= op2_q;
      op4_q <= op3_q;
    end
  end

  // ---- stage 1: offsets from the two corners ----
  logic signed [RW-1:0] r1x_q, r1y_q, r2x_q, r2y_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1x_q <= RW'(q_px) - ax_q;
      r1y_q <= RW'(q_py) - ay_q;
      r2x_q <= RW'(q_px) - cx_q;
      r2y_q <= RW'(q_py) - cy_q;
    end
  end

  // ---- stage 2: split partial products ----
  logic signed [AW-1:0] mul_a [NMUL];
  logic signed [RW-1:0] mul_b [NMUL];
  logic signed [AW+LO:0]   plo_q [NMUL];
  logic signed [AW+HI-1:0] phi_q [NMUL];

  // dot products: e.r1, d.r1, d.r2, e.r2
  always_comb begin
    mul_a[0] = ex_q;  mul_b[0] = r1x_q;
    mul_a[1] = ey_q;  mul_b[1] = r1y_q;
    mul_a[2] = dxa_q; mul_b[2] = r1x_q;
    mul_a[3] = dya_q; mul_b[3] = r1y_q;
    mul_a[4] = dxa_q; mul_b[4] = r2x_q;
    mul_a[5] = dya_q; mul_b[5] = r2y_q;
    mul_a[6] = ex_q;  mul_b[6] = r2x_q;
    mul_a[7] = ey_q;  mul_b[7] = r2y_q;
  end

  // ---- stage 3: recombine each product ----
  logic signed [PW-1:0] prod_q [NMUL];

  for (genvar k = 0; k < NMUL; k++) begin : g_mul
    logic signed [LO:0]   b_lo;
    logic signed [HI-1:0] b_hi;
    logic signed [PW-1:0] hi_sh, lo_ext;

    assign b_lo = $signed({1'b0, mul_b[k][LO-1:0]});
    assign b_hi = mul_b[k][RW-1:LO];

    always_ff @(posedge clk_i) begin
      if (en) begin
        plo_q[k] <= mul_a[k] * b_lo;
        phi_q[k] <= mul_a[k] * b_hi;
      end
    end

    assign hi_sh  = {phi_q[k], {LO{1'b0}}};
    assign lo_ext = PW'(plo_q[k]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        prod_q[k] <= hi_sh + lo_ext;
      end
    end
  end

  // ---- stage 4: dot product signs and the inside decision ----
  logic signed [SW-1:0] dot [4];
  logic [3:0] nonneg, nonpos;
  logic       inside_q;

  for (genvar j = 0; j < 4; j++) begin : g_dot
    assign dot[j]    = SW'(prod_q[2*j]) + SW'(prod_q[2*j+1]);
    assign nonneg[j] = !dot[j][SW-1];
    assign nonpos[j] = dot[j][SW-1] || (dot[j] == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inside_q <= nonneg[0] && nonpos[1] && nonneg[2] && nonpos[3];
    end
  end

  // ---- commit: occupancy state ----
  logic          set_hit_q, set_hit_d;
  logic [TW-1:0] ticks_q, ticks_d;
  logic          commit;

  assign commit = en && v4_q;

  always_comb begin
    set_hit_d = set_hit_q;
    ticks_d   = ticks_q;
    res_wr_o  = 1'b0;
    res_o.occupied   = set_hit_q || (ticks_q <= min_free_i);
    res_o.hit_in_set = set_hit_q;
    if (commit) begin
      unique case (op4_q)
        zoh_pkg::OP_TICK: begin
          if (ticks_q != '1) begin
            ticks_d = ticks_q + 1'b1;
          end
        end
        zoh_pkg::OP_POINT: begin
          if (inside_q) begin
            set_hit_d = 1'b1;
          end
        end
        zoh_pkg::OP_FINISH: begin
          res_wr_o  = 1'b1;
          set_hit_d = 1'b0;
          if (set_hit_q) begin
            ticks_d = '0;
          end
        end
        default: begin
          set_hit_d = set_hit_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_hit_q <= 1'b0;
      ticks_q   <= '1;
    end else begin
      set_hit_q <= set_hit_d;
      ticks_q   <= ticks_d;
    end
  end

endmodule

>>> rtl/core/zone_occupancy_with_holdoff.sv
// ----------------------------------------------------------------------------
// zone_occupancy_with_holdoff
// rectangular zone occupancy with hold-off timer, one request per cycle
// ----------------------------------------------------------------------------
// Requests arrive as ticks, points or finish marks, one per clock while full
// is low. A point is tested against the zone rectangle spanned by end one,
// end two and the half-width offset; boundary points count as inside. A
// finish closes the current set of points and queues exactly one result:
// hit_in_set tells whether any point of the set was inside, and occupied
// stays high until more than min_free_ticks ticks have passed since the last
// set with a hit (after reset the zone reads free). Action code 3 is taken
// and ignored. Throughput is one request per clock while full is low; a result
// reaches the result ports after its finish request has passed through the
// intake register, the operation queue, the four stage geometry pipeline
// (corner offsets, split partial products, product recombination, dot
// product signs) and the write into the result queue. Only a full result
// queue stalls the pipeline, and the operation queue between intake and
// pipeline absorbs short stalls.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i and must only change while the block is idle.
// ----------------------------------------------------------------------------
module zone_occupancy_with_holdoff #(
  parameter int COORD_WIDTH = zoh_pkg::COORD_WIDTH_DEF,
  parameter int TIMER_WIDTH = zoh_pkg::TIMER_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [zoh_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [((COORD_WIDTH > TIMER_WIDTH) ?
                 ((COORD_WIDTH > zoh_pkg::HALF_WIDTH_BITS) ?
                  COORD_WIDTH : zoh_pkg::HALF_WIDTH_BITS) :
                 ((TIMER_WIDTH > zoh_pkg::HALF_WIDTH_BITS) ?
                  TIMER_WIDTH : zoh_pkg::HALF_WIDTH_BITS))-1:0] cfg_data_i,
  // request side
  input  logic                          push,
  output logic                          full,
  input  logic [zoh_pkg::ACTION_W-1:0]  action_i,
  input  logic [COORD_WIDTH-1:0]        point_x_i,
  input  logic [COORD_WIDTH-1:0]        point_y_i,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output logic                          occupied_o,
  output logic                          hit_in_set_o
);

  localparam int CW = COORD_WIDTH;
  localparam int TW = TIMER_WIDTH;
  localparam int HW = zoh_pkg::HALF_WIDTH_BITS;
  localparam int QW = zoh_pkg::OP_W + 2 * CW;

  // configuration registers
  logic signed [CW-1:0] e1x_q, e1y_q, e2x_q, e2y_q;
  logic signed [HW-1:0] dx_q, dy_q;
  logic [TW-1:0]        min_free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1x_q      <= '0;
      e1y_q      <= '0;
      e2x_q      <= '0;
      e2y_q      <= '0;
      dx_q       <= '0;
      dy_q       <= '0;
      min_free_q <= TW'(zoh_pkg::HOLDOFF_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        zoh_pkg::REG_END_ONE_X:     e1x_q      <= cfg_data_i[CW-1:0];
        zoh_pkg::REG_END_ONE_Y:     e1y_q      <= cfg_data_i[CW-1:0];
        zoh_pkg::REG_END_TWO_X:     e2x_q      <= cfg_data_i[CW-1:0];
        zoh_pkg::REG_END_TWO_Y:     e2y_q      <= cfg_data_i[CW-1:0];
        zoh_pkg::REG_HALF_WIDTH_DX: dx_q       <= cfg_data_i[HW-1:0];
        zoh_pkg::REG_HALF_WIDTH_DY: dy_q       <= cfg_data_i[HW-1:0];
        zoh_pkg::REG_MIN_FREE:      min_free_q <= cfg_data_i[TW-1:0];
        default: begin
          // index beyond the register list: write ignored
          min_free_q <= min_free_q;
        end
      endcase
    end
  end

  // front: intake and classification
  logic          mq_wr, mq_full, mq_rd, mq_empty;
  logic [QW-1:0] mq_wdata, mq_rdata;

  zoh_front #(
    .CW (CW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .action_i  (action_i),
    .point_x_i (point_x_i),
    .point_y_i (point_y_i),
    .q_wr_o    (mq_wr),
    .q_wdata_o (mq_wdata),
    .q_full_i  (mq_full)
  );

  // operation queue between front and back
  zoh_fifo #(
    .WIDTH (QW),
    .DEPTH (zoh_pkg::MID_DEPTH)
  ) u_op_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (mq_wr),
    .wdata_i (mq_wdata),
    .full_o  (mq_full),
    .rd_i    (mq_rd),
    .rdata_o (mq_rdata),
    .empty_o (mq_empty)
  );

  // back: geometry pipeline and occupancy state
  logic                 res_wr, res_full;
  zoh_pkg::zoh_result_t res_in, res_out;

  zoh_back #(
    .CW (CW),
    .TW (TW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (mq_empty),
    .q_rdata_i  (mq_rdata),
    .q_rd_o     (mq_rd),
    .e1x_i      (e1x_q),
    .e1y_i      (e1y_q),
    .e2x_i      (e2x_q),
    .e2y_i      (e2y_q),
    .dx_i       (dx_q),
    .dy_i       (dy_q),
    .min_free_i (min_free_q),
    .res_wr_o   (res_wr),
    .res_o      (res_in),
    .res_full_i (res_full)
  );

  // result queue towards the consumer
  zoh_fifo #(
    .WIDTH ($bits(zoh_pkg::zoh_result_t)),
    .DEPTH (zoh_pkg::OUT_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .wdata_i (res_in),
    .full_o  (res_full),
    .rd_i    (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign occupied_o   = res_out.occupied;
  assign hit_in_set_o = res_out.hit_in_set;

endmodule

>>> verif/tb_zone_occupancy_with_holdoff.sv
// ----------------------------------------------------------------------------
// tb_zone_occupancy_with_holdoff
// self-checking bench for the zone occupancy block with hold-off timer
// ----------------------------------------------------------------------------
// Requests (ticks, points, finish marks) go in through the push/full queue
// port and reports come out through the empty/pop port. A scoreboard class
// keeps its own copy of the zone registers, the set flag and the tick
// counter, works out the report for every finish request as it is taken, and
// checks each popped report against the oldest one waiting. A directed part
// covers the reset state, the degenerate zone, the boundary, the hold-off
// threshold and the unused action, then random sets of requests run under
// several zone settings with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_zone_occupancy_with_holdoff;
  timeunit 1ns;
  timeprecision 1ps;

  import zoh_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int TW = TIMER_WIDTH_DEF;
  localparam int DATA_W = (CW > TW) ? ((CW > HALF_WIDTH_BITS) ? CW : HALF_WIDTH_BITS) :
                                      ((TW > HALF_WIDTH_BITS) ? TW : HALF_WIDTH_BITS);

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 9;
  // time for the pipeline to run dry, with ample margin
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 160;
  localparam int LIMIT_CYCLES  = 400_000;

  // action code the block takes and ignores
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // --------------------------------------------------------------------------
  // scoreboard: zone registers, set flag and tick counter of the block
  // --------------------------------------------------------------------------
  class zone_occupancy_predictor;
    logic signed [CW-1:0]              e1x, e1y, e2x, e2y;
    logic signed [HALF_WIDTH_BITS-1:0] hdx, hdy;
    logic [TW-1:0]                     min_free_ticks;
    logic                              set_hit;
    logic [TW-1:0]                     ticks_since_hit;
    zoh_result_t                       expected_reports[$];
    int unsigned                       mismatches;

    function new();
      e1x = '0;
      e1y = '0;
      e2x = '0;
      e2y = '0;
      hdx = '0;
      hdy = '0;
      min_free_ticks = TW'(HOLDOFF_RESET);
      set_hit = 1'b0;
      ticks_since_hit = '1;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_END_ONE_X:     e1x = data[CW-1:0];
        REG_END_ONE_Y:     e1y = data[CW-1:0];
        REG_END_TWO_X:     e2x = data[CW-1:0];
        REG_END_TWO_Y:     e2y = data[CW-1:0];
        REG_HALF_WIDTH_DX: hdx = data[HALF_WIDTH_BITS-1:0];
        REG_HALF_WIDTH_DY: hdy = data[HALF_WIDTH_BITS-1:0];
        REG_MIN_FREE:      min_free_ticks = data[TW-1:0];
        default: ;
      endcase
    endfunction

    // exact sign of a two-term dot product
    function bit dot_nonneg(longint ax, longint ay, longint bx, longint by);
      logic signed [127:0] wax, way, wbx, wby, sum;
      wax = ax;
      way = ay;
      wbx = bx;
      wby = by;
      sum = wax * wbx + way * wby;
      return !sum[127];
    endfunction

    // edge tests against corner E1 + D and corner E2 - D, boundary inclusive
    function bit point_in_zone(logic signed [CW-1:0] px, logic signed [CW-1:0] py);
      longint ex, ey, dx, dy, r1x, r1y, r2x, r2y;
      dx  = hdx;
      dy  = hdy;
      ex  = longint'(e2x) - longint'(e1x);
      ey  = longint'(e2y) - longint'(e1y);
      r1x = longint'(px) - (longint'(e1x) + dx);
      r1y = longint'(py) - (longint'(e1y) + dy);
      r2x = longint'(px) - (longint'(e2x) - dx);
      r2y = longint'(py) - (longint'(e2y) - dy);
      return dot_nonneg(ex, ey, r1x, r1y) && dot_nonneg(-dx, -dy, r1x, r1y) &&
             dot_nonneg(dx, dy, r2x, r2y) && dot_nonneg(-ex, -ey, r2x, r2y);
    endfunction

    function void note_request(logic [ACTION_W-1:0] act, logic [CW-1:0] px,
                               logic [CW-1:0] py);
      zoh_result_t rep;
      case (act)
        ACT_TICK: begin
          if (ticks_since_hit != '1) ticks_since_hit = ticks_since_hit + 1'b1;
        end
        ACT_POINT: begin
          if (point_in_zone(px, py)) set_hit = 1'b1;
        end
        ACT_FINISH: begin
          rep.hit_in_set = set_hit;
          if (set_hit) begin
            ticks_since_hit = '0;
            rep.occupied = 1'b1;
          end else begin
            rep.occupied = !(ticks_since_hit > min_free_ticks);
          end
          set_hit = 1'b0;
          expected_reports.insert(expected_reports.size(), rep);
        end
        default: ;
      endcase
    endfunction

    function void check_report(logic occupied, logic hit_in_set);
      zoh_result_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: report with none expected, expected nothing actual occ %0b hit %0b",
                 $time, occupied, hit_in_set);
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      if (occupied !== want.occupied) begin
        $display("%0t: occupied mismatch, expected %0b actual %0b",
                 $time, want.occupied, occupied);
        mismatches++;
      end
      if (hit_in_set !== want.hit_in_set) begin
        $display("%0t: hit_in_set mismatch, expected %0b actual %0b",
                 $time, want.hit_in_set, hit_in_set);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and block under test
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;
  logic                 push;
  logic                 full;
  logic [ACTION_W-1:0]  action_i;
  logic [CW-1:0]        point_x_i;
  logic [CW-1:0]        point_y_i;
  logic                 empty;
  logic                 pop;
  logic                 occupied_o;
  logic                 hit_in_set_o;

  zone_occupancy_predictor zone = new();

  // gap control shared by the sender and receiver processes
  bit          tx_idle    = 1'b1;
  bit          rx_idle    = 1'b1;
  bit          hold_req   = 1'b0;
  bit          rx_holding = 1'b0;
  int unsigned sent_items = 0;

  zone_occupancy_with_holdoff #(
    .COORD_WIDTH(CW),
    .TIMER_WIDTH(TW)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .push,
    .full,
    .action_i,
    .point_x_i,
    .point_y_i,
    .empty,
    .pop,
    .occupied_o,
    .hit_in_set_o
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // request side: inputs move on the falling edge, full is looked at on the
  // rising edge, so a request is taken when push is high and full low there
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [CW-1:0] px,
                              input logic [CW-1:0] py);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    push      <= 1'b1;
    action_i  <= act;
    point_x_i <= px;
    point_y_i <= py;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    zone.note_request(act, px, py);
    // ignored requests do not count towards the stimulus length
    if (act != ACT_UNUSED) sent_items++;
    @(negedge clk_i);
  endtask

  // wait for every expected report, then for the pipeline to run dry, since
  // ticks and points give no report of their own
  task automatic drain_reports();
    push <= 1'b0;
    while (zone.expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    zone.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // all seven registers, only ever called with the block idle
  task automatic program_zone(input logic [DATA_W-1:0] e1x, e1y, e2x, e2y, dx, dy, mf);
    write_cfg(REG_END_ONE_X, e1x);
    write_cfg(REG_END_ONE_Y, e1y);
    write_cfg(REG_END_TWO_X, e2x);
    write_cfg(REG_END_TWO_Y, e2y);
    write_cfg(REG_HALF_WIDTH_DX, dx);
    write_cfg(REG_HALF_WIDTH_DY, dy);
    write_cfg(REG_MIN_FREE, mf);
    cfg_we_i <= 1'b0;
  endtask

  // half-width value with junk above bit 20, which the block must drop
  function automatic logic [DATA_W-1:0] half_width_word(int val);
    logic [DATA_W-1:0] w;
    w = $urandom;
    w[HALF_WIDTH_BITS-1:0] = val[HALF_WIDTH_BITS-1:0];
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] near_coord();
    return DATA_W'(int'($urandom_range(0, 10000)) - 5000);
  endfunction

  // point around the current zone: mostly spread over it and a margin,
  // sometimes a corner with a step of one either way, sometimes anywhere
  task automatic pick_point(output logic [CW-1:0] px, output logic [CW-1:0] py);
    longint ex, ey, dx, dy, u, v, bx, by;
    int unsigned mode;
    ex   = longint'(zone.e2x) - longint'(zone.e1x);
    ey   = longint'(zone.e2y) - longint'(zone.e1y);
    dx   = zone.hdx;
    dy   = zone.hdy;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      // along the segment -20 %..120 %, across the width -120 %..120 %
      u  = longint'($urandom_range(0, 1400)) - 200;
      v  = longint'($urandom_range(0, 2400)) - 1200;
      bx = longint'(zone.e1x) + ex * u / 1000 + dx * v / 1000;
      by = longint'(zone.e1y) + ey * u / 1000 + dy * v / 1000;
    end else if (mode < 8) begin
      bx = longint'(zone.e1x) + (($urandom_range(0, 1)) ? dx : -dx);
      by = longint'(zone.e1y) + (($urandom_range(0, 1)) ? dy : -dy);
      if ($urandom_range(0, 1)) begin
        bx = bx + ex;
        by = by + ey;
      end
      bx = bx + longint'($urandom_range(0, 2)) - 1;
      by = by + longint'($urandom_range(0, 2)) - 1;
    end else begin
      bx = longint'($urandom);
      by = longint'($urandom);
    end
    px = CW'(bx);
    py = CW'(by);
  endtask

  task automatic tick_run();
    int unsigned n;
    // mostly short runs, now and then long enough to cross the hold-off
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 2);
    repeat (n) send_request(ACT_TICK, $urandom, $urandom);
  endtask

  // one set: ticks and points, a little noise, usually closed by a finish
  task automatic run_set();
    int unsigned n_points;
    bit quiet;
    logic [CW-1:0] px, py;
    quiet    = ($urandom_range(0, 9) < 4);
    n_points = $urandom_range(0, 5);
    repeat (n_points) begin
      tick_run();
      if (quiet || $urandom_range(0, 4) == 0) begin
        px = $urandom;
        py = $urandom;
      end else begin
        pick_point(px, py);
      end
      send_request(ACT_POINT, px, py);
      if ($urandom_range(0, 19) == 0) send_request(ACT_UNUSED, $urandom, $urandom);
    end
    tick_run();
    // an unclosed set just runs on into the next one
    if ($urandom_range(0, 9) != 0) send_request(ACT_FINISH, $urandom, $urandom);
  endtask

  // --------------------------------------------------------------------------
  // result side: pop moves on the falling edge, reports taken on the rising
  // edge; a long hold-off on request lets the block fill up
  // --------------------------------------------------------------------------
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        pop        <= 1'b0;
        hold_req    = 1'b0;
        rx_holding  = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        rx_holding  = 1'b0;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      if (!empty) zone.check_report(occupied_o, hit_in_set_o);
      @(negedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CW-1:0] px, py;
    int unsigned phase_start;
    bit keep_idle;

    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    push       = 1'b0;
    action_i   = ACT_TICK;
    point_x_i  = '0;
    point_y_i  = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset zone is a single point at the origin with no width: every dot
    // product is zero, so every point counts as inside; counter starts
    // saturated so the zone reads free and a tick leaves it at its maximum
    send_request(ACT_TICK, '0, '0);
    send_request(ACT_FINISH, '1, '1);
    // unused action with a point that would hit: must leave no trace
    send_request(ACT_UNUSED, 32'h7fff_ffff, 32'h8000_0000);
    send_request(ACT_FINISH, '0, '0);
    send_request(ACT_POINT, 32'h7fff_ffff, 32'h8000_0000);
    send_request(ACT_FINISH, '0, '0);
    // no hit, counter freshly cleared: still within hold-off
    send_request(ACT_FINISH, '0, '0);
    drain_reports();

    // plain box along x from 0 to 1000, 250 either side, hold-off of 2 ticks
    program_zone('0, '0, DATA_W'(1000), '0, half_width_word(0), half_width_word(250),
                 DATA_W'(2));
    send_request(ACT_POINT, CW'(0), CW'(250));        // corner, on the boundary
    send_request(ACT_FINISH, '0, '0);
    send_request(ACT_POINT, CW'(0), CW'(251));        // just past each edge
    send_request(ACT_POINT, CW'(-1), CW'(0));
    send_request(ACT_POINT, CW'(1001), CW'(0));
    send_request(ACT_POINT, CW'(500), CW'(-251));
    send_request(ACT_FINISH, '0, '0);
    send_request(ACT_TICK, '0, '0);                   // counter equal to limit
    send_request(ACT_TICK, '0, '0);
    send_request(ACT_FINISH, '0, '0);
    send_request(ACT_TICK, '0, '0);                   // one past the limit
    send_request(ACT_FINISH, '0, '0);
    send_request(ACT_POINT, CW'(1000), CW'(-250));    // opposite corner
    send_request(ACT_POINT, 32'h8000_0000, 32'h7fff_ffff);
    send_request(ACT_FINISH, '0, '0);
    send_request(ACT_POINT, 32'h7fff_ffff, 32'h8000_0000);
    send_request(ACT_POINT, 32'h8000_0000, 32'h8000_0000);
    send_request(ACT_FINISH, '0, '0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_reports();
      // last phase runs flat out on both sides
      if (ph == RANDOM_PHASES - 1) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      case (ph)
        0: program_zone(near_coord(), near_coord(), near_coord(), near_coord(),
                        half_width_word(int'($urandom_range(0, 1200)) - 600),
                        half_width_word(int'($urandom_range(0, 1200)) - 600),
                        DATA_W'($urandom_range(0, 20)));
        1: program_zone(near_coord(), near_coord(), near_coord(), near_coord(),
                        half_width_word(int'($urandom_range(0, 1200)) - 600),
                        half_width_word(int'($urandom_range(0, 1200)) - 600), '0);
        2: program_zone(near_coord(), near_coord(), near_coord(), near_coord(),
                        half_width_word(int'($urandom_range(0, 1200)) - 600),
                        half_width_word(int'($urandom_range(0, 1200)) - 600),
                        DATA_W'(HOLDOFF_RESET));
        // corners at the ends of the coordinate range, widest offsets, and a
        // hold-off at its maximum so the zone never reads free after a hit
        3: program_zone(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                        32'hfff0_0000, 32'h000f_ffff, '1);
        // zero-length segment
        4: begin
          px = near_coord();
          py = near_coord();
          program_zone(px, py, px, py,
                       half_width_word(int'($urandom_range(0, 1200)) - 600),
                       half_width_word(int'($urandom_range(0, 1200)) - 600), DATA_W'(5));
        end
        // zero width
        5: program_zone(near_coord(), near_coord(), near_coord(), near_coord(),
                        half_width_word(0), half_width_word(0), DATA_W'(3));
        6: program_zone($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom);
        default: program_zone(near_coord(), near_coord(), near_coord(), near_coord(),
                              half_width_word(int'($urandom_range(0, 1200)) - 600),
                              half_width_word(int'($urandom_range(0, 1200)) - 600),
                              DATA_W'($urandom_range(0, 10)));
      endcase

      // back-pressure: receiver stops for a long stretch while requests keep
      // coming with no gaps, so the result queue fills and full rises
      if (ph == 2) begin
        keep_idle = tx_idle;
        tx_idle   = 1'b0;
        hold_req  = 1'b1;
        while (!rx_holding) @(negedge clk_i);
        repeat (30) begin
          pick_point(px, py);
          send_request(ACT_POINT, px, py);
          send_request(ACT_FINISH, $urandom, $urandom);
        end
        tx_idle = keep_idle;
      end

      phase_start = sent_items;
      while (sent_items - phase_start < PHASE_ITEMS) run_set();
    end
    drain_reports();

    if (zone.mismatches == 0 && zone.expected_reports.size() == 0) begin
      $display("tb_zone_occupancy_with_holdoff OK");
    end else begin
      $display("tb_zone_occupancy_with_holdoff NOT OK");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("tb_zone_occupancy_with_holdoff NOT OK");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/zoh_pkg.sv
rtl/core/zoh_fifo.sv
rtl/core/zoh_front.sv
rtl/core/zoh_back.sv
rtl/core/zone_occupancy_with_holdoff.sv
verif/tb_zone_occupancy_with_holdoff.sv
